/* design/udp_ipv4_eth_header_builder_macros.svh */
// Assertion macros for the UDP/IPv4/Ethernet header builder.
// Used by the port checker; no other dependencies.
`ifndef UDP_IPV4_ETH_HEADER_BUILDER_MACROS_SVH
`define UDP_IPV4_ETH_HEADER_BUILDER_MACROS_SVH

// same-cycle implication
`define UIEB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UIEB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/uieb_pkg.sv */
// Shared types and constants for the UDP/IPv4/Ethernet header builder.
// No dependencies.
package uieb_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int HDR_BYTES   = 42;
	localparam int POS_W       = 6;

	localparam logic [POS_W-1:0] POS_LAST_IP  = 6'd33;
	localparam logic [POS_W-1:0] POS_LAST_UDP = 6'd41;
	localparam logic [POS_W-1:0] POS_ETHERTYPE_HI = 6'd12;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  IP_VER_IHL     = 8'h45;
	localparam logic [15:0] IP_IDENT       = 16'h0001;
	localparam logic [7:0]  IP_TTL         = 8'h10;
	localparam logic [16:0] IP_HDR_LEN     = 17'd20;
	localparam logic [16:0] UDP_HDR_LEN    = 17'd8;

	typedef enum logic {
		REG_SOURCE_MAC      = 1'b0,
		REG_DESTINATION_MAC = 1'b1
	} uieb_reg_idx_t;

	typedef struct packed {
		logic [15:0] payload_length;
		logic        add_udp;
		logic [15:0] source_port;
		logic [15:0] destination_port;
		logic [31:0] source_ip;
		logic [31:0] destination_ip;
		logic [7:0]  ip_protocol;
	} uieb_request_t;

	typedef struct packed {
		logic [7:0]       header_byte;
		logic [POS_W-1:0] byte_position;
		logic             last_byte;
		logic             oversize;
	} uieb_result_t;

	typedef struct packed {
		logic [47:0] source_mac;
		logic [47:0] destination_mac;
	} uieb_mac_cfg_t;

	typedef struct packed {
		logic        oversize;
		logic        add_udp;
		logic [15:0] total_length;
		logic [15:0] udp_length;
		logic [15:0] checksum;
		logic [15:0] source_port;
		logic [15:0] destination_port;
		logic [31:0] source_ip;
		logic [31:0] destination_ip;
		logic [7:0]  ip_protocol;
	} uieb_desc_t;

endpackage

/* design/udp_ipv4_eth_header_builder.sv */
// UDP/IPv4/Ethernet header builder: a taken request passes the front-end registers, the queue
// and the serializer, then 34 bytes (42 with UDP, 1 if oversize) follow on consecutive cycles, one byte per cycle.
// Sustained throughput is set by the byte serializer;
// the front end and a 4-entry descriptor queue take new requests while it runs.
// Asynchronous active-low reset clears the pipeline, queue and serializer; MACs reset to 0.
// Results cannot be stalled by the receiver. Depends on uieb_pkg, uieb_front/queue/back.
module udp_ipv4_eth_header_builder import uieb_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  uieb_request_t request,
	output uieb_result_t  result,
	output logic          result_strobe,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [63:0]   pwdata,
	output logic [63:0]   prdata,
	output logic          pready
);

	localparam int CNT_W = $clog2(QDEPTH+1);

	uieb_mac_cfg_t    mac_q;
	logic             take;
	logic [1:0]       pending;
	logic             push;
	uieb_desc_t       wr_desc;
	logic             pop;
	uieb_desc_t       head;
	logic             empty;
	logic [CNT_W-1:0] count;
	logic [CNT_W+1:0] inflight;
	logic             cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_q <= '0;
		end else if (cfg_write) begin
			case (uieb_reg_idx_t'(paddr[3]))
				REG_SOURCE_MAC:      mac_q.source_mac      <= pwdata[47:0];
				REG_DESTINATION_MAC: mac_q.destination_mac <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (uieb_reg_idx_t'(paddr[3]))
			REG_SOURCE_MAC:      prdata = {16'h0000, mac_q.source_mac};
			REG_DESTINATION_MAC: prdata = {16'h0000, mac_q.destination_mac};
			default:             prdata = '0;
		endcase
	end

	assign inflight = {2'b00, count} + {{CNT_W{1'b0}}, pending};
	assign busy     = (inflight >= (CNT_W+2)'(QDEPTH));
	assign take     = start && !busy;

	uieb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.request (request),
		.pending (pending),
		.push    (push),
		.desc    (wr_desc)
	);

	uieb_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_desc (wr_desc),
		.pop     (pop),
		.head    (head),
		.empty   (empty),
		.count   (count)
	);

	uieb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.mac           (mac_q),
		.head          (head),
		.empty         (empty),
		.pop           (pop),
		.result        (result),
		.result_strobe (result_strobe)
	);

endmodule

/* design/uieb_front.sv */
// Front end: registers a request, computes lengths and the IPv4 header checksum.
// Depends on uieb_pkg.
module uieb_front import uieb_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  uieb_request_t request,
	output logic [1:0]    pending,
	output logic          push,
	output uieb_desc_t    desc
);

	logic          v_s1;
	uieb_request_t req_s1;
	logic          v_s2;
	uieb_request_t req_s2;
	logic [16:0]   total_s2;
	logic [18:0]   part_s2;

	logic [16:0] total;
	logic [18:0] part;
	logic [18:0] sum;
	logic [16:0] fold1;
	logic [15:0] fold2;

	always_comb begin
		total = {1'b0, req_s1.payload_length} + IP_HDR_LEN
			+ (req_s1.add_udp ? UDP_HDR_LEN : 17'd0);
		part = {3'b0, IP_VER_IHL, 8'h00} + {3'b0, IP_IDENT} + {3'b0, IP_TTL, req_s1.ip_protocol}
			+ {3'b0, req_s1.source_ip[31:16]} + {3'b0, req_s1.source_ip[15:0]}
			+ {3'b0, req_s1.destination_ip[31:16]} + {3'b0, req_s1.destination_ip[15:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= request;
		end
		if (v_s1) begin
			req_s2   <= req_s1;
			total_s2 <= total;
			part_s2  <= part;
		end
	end

	always_comb begin
		sum   = part_s2 + {3'b0, total_s2[15:0]};
		fold1 = {1'b0, sum[15:0]} + {14'b0, sum[18:16]};
		fold2 = fold1[15:0] + {15'b0, fold1[16]};
		desc.oversize         = total_s2[16];
		desc.add_udp          = req_s2.add_udp;
		desc.total_length     = total_s2[15:0];
		desc.udp_length       = req_s2.payload_length + 16'd8;
		desc.checksum         = ~fold2;
		desc.source_port      = req_s2.source_port;
		desc.destination_port = req_s2.destination_port;
		desc.source_ip        = req_s2.source_ip;
		desc.destination_ip   = req_s2.destination_ip;
		desc.ip_protocol      = req_s2.ip_protocol;
	end

	assign push    = v_s2;
	assign pending = {1'b0, v_s1} + {1'b0, v_s2};

endmodule

/* design/uieb_queue.sv */
// Descriptor queue between front end and byte serializer.
// Depends on uieb_pkg.
module uieb_queue import uieb_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  uieb_desc_t                 wr_desc,
	input  logic                       pop,
	output uieb_desc_t                 head,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	uieb_desc_t       mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_desc;
		end
	end

	assign head  = mem[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

endmodule

/* design/uieb_back.sv */
// Back end: serializes one header byte per cycle from the queue head.
// Depends on uieb_pkg.
module uieb_back import uieb_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  uieb_mac_cfg_t mac,
	input  uieb_desc_t    head,
	input  logic          empty,
	output logic          pop,
	output uieb_result_t  result,
	output logic          result_strobe
);

	localparam int HDR_BITS = 8 * HDR_BYTES;

	uieb_desc_t       cur_q;
	logic             active_q;
	logic [POS_W-1:0] pos_q;
	uieb_result_t     result_q;
	logic             result_strobe_q;

	logic [HDR_BITS-1:0] hdr;
	logic [POS_W-1:0]    sel;
	logic [7:0]          hdr_byte;
	logic                last;

	always_comb begin
		hdr = {mac.destination_mac, mac.source_mac, ETHERTYPE_IPV4, IP_VER_IHL, 8'h00,
			cur_q.total_length, IP_IDENT, 16'h0000, IP_TTL, cur_q.ip_protocol,
			cur_q.checksum, cur_q.source_ip, cur_q.destination_ip, cur_q.source_port,
			cur_q.destination_port, cur_q.udp_length, 16'h0000};
		sel      = POS_W'(HDR_BYTES - 1) - pos_q;
		hdr_byte = hdr[{sel, 3'b000} +: 8];
		last     = cur_q.oversize || (pos_q == (cur_q.add_udp ? POS_LAST_UDP : POS_LAST_IP));
		pop      = !empty && (!active_q || last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q        <= 1'b0;
			pos_q           <= '0;
			result_strobe_q <= 1'b0;
		end else begin
			result_strobe_q <= active_q;
			if (pop) begin
				active_q <= 1'b1;
				pos_q    <= '0;
			end else if (active_q && last) begin
				active_q <= 1'b0;
				pos_q    <= '0;
			end else if (active_q) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (active_q) begin
			result_q.header_byte   <= cur_q.oversize ? 8'h00 : hdr_byte;
			result_q.byte_position <= cur_q.oversize ? '0 : pos_q;
			result_q.last_byte     <= last;
			result_q.oversize      <= cur_q.oversize;
		end
	end

	assign result        = result_q;
	assign result_strobe = result_strobe_q;

endmodule

/* design/uieb_checker.sv */
// Port-level checker for the header builder, bound to the top level.
// Depends on uieb_pkg and udp_ipv4_eth_header_builder_macros.svh.
`include "udp_ipv4_eth_header_builder_macros.svh"

module uieb_checker import uieb_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input uieb_result_t result,
	input logic         result_strobe
);

	`UIEB_ASSERT_NOW(a_oversize_single, clk, arst_n, result_strobe && result.oversize, result.last_byte && (result.byte_position == '0) && (result.header_byte == 8'h00), "oversize transaction must be a single zero byte")

	`UIEB_ASSERT_NEXT(a_bytes_contiguous, clk, arst_n, result_strobe && !result.last_byte, result_strobe && (result.byte_position == $past(result.byte_position) + 6'd1), "header bytes must be back to back")

	`UIEB_ASSERT_NOW(a_last_position, clk, arst_n, result_strobe && result.last_byte && !result.oversize, (result.byte_position == POS_LAST_IP) || (result.byte_position == POS_LAST_UDP), "last byte at wrong position")

	`UIEB_ASSERT_NOW(a_ethertype, clk, arst_n, result_strobe && !result.oversize && (result.byte_position == POS_ETHERTYPE_HI), result.header_byte == ETHERTYPE_IPV4[15:8], "ethertype high byte wrong")

endmodule

bind udp_ipv4_eth_header_builder uieb_checker u_uieb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.result        (result),
	.result_strobe (result_strobe)
);

/* sim/header_stream_checker.sv */
`timescale 1ns / 100ps
// Checker for the UDP/IPv4/Ethernet header builder: follows MAC writes and requests,
// predicts every header byte and compares each result strobe. Depends on uieb_pkg.
module header_stream_checker import uieb_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  uieb_request_t request,
	input  uieb_result_t  result,
	input  logic          result_strobe,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [63:0]   pwdata,
	input  logic          pready,
	output int            mismatches,
	output int            outstanding
);

	logic [47:0] src_mac = '0;
	logic [47:0] dst_mac = '0;
	uieb_result_t header_bytes_due[$];
	int result_count = 0;
	int mismatch_count = 0;
	int due_count = 0;

	assign mismatches  = mismatch_count;
	assign outstanding = due_count;

	task automatic report_mismatch(string what);
		$display("%0t: result %0d: %s", $realtime, result_count, what);
		mismatch_count++;
	endtask

	task automatic queue_header(uieb_request_t r);
		logic [7:0] hdr [HDR_BYTES];
		logic [16:0] total;
		logic [31:0] sum;
		uieb_result_t res;
		int n;
		total = {1'b0, r.payload_length} + IP_HDR_LEN + (r.add_udp ? UDP_HDR_LEN : 17'd0);
		if (total[16]) begin
			res = '0;
			res.last_byte = 1'b1;
			res.oversize = 1'b1;
			header_bytes_due.push_back(res);
			return;
		end
		for (int i = 0; i < 6; i++) begin
			hdr[i] = dst_mac[47 - 8*i -: 8];
			hdr[6 + i] = src_mac[47 - 8*i -: 8];
		end
		{hdr[12], hdr[13]} = ETHERTYPE_IPV4;
		hdr[14] = IP_VER_IHL;
		hdr[15] = 8'h00;
		{hdr[16], hdr[17]} = total[15:0];
		{hdr[18], hdr[19]} = IP_IDENT;
		{hdr[20], hdr[21]} = 16'h0000;
		hdr[22] = IP_TTL;
		hdr[23] = r.ip_protocol;
		{hdr[24], hdr[25]} = 16'h0000;
		{hdr[26], hdr[27], hdr[28], hdr[29]} = r.source_ip;
		{hdr[30], hdr[31], hdr[32], hdr[33]} = r.destination_ip;
		// one's-complement sum, carries folded back until none remain
		sum = '0;
		for (int i = 14; i < 34; i += 2)
			sum += {hdr[i], hdr[i + 1]};
		while (sum > 32'h0000_FFFF)
			sum = sum[15:0] + sum[31:16];
		{hdr[24], hdr[25]} = ~sum[15:0];
		n = POS_LAST_IP + 1;
		if (r.add_udp) begin
			{hdr[34], hdr[35]} = r.source_port;
			{hdr[36], hdr[37]} = r.destination_port;
			{hdr[38], hdr[39]} = r.payload_length + UDP_HDR_LEN[15:0];
			{hdr[40], hdr[41]} = 16'h0000;
			n = HDR_BYTES;
		end
		for (int i = 0; i < n; i++) begin
			res.header_byte = hdr[i];
			res.byte_position = POS_W'(i);
			res.last_byte = (i == n - 1);
			res.oversize = 1'b0;
			header_bytes_due.push_back(res);
		end
	endtask

	always @(posedge clk) begin
		uieb_result_t want;
		if (arst_n) begin
			if (result_strobe) begin
				if (header_bytes_due.size() == 0) begin
					report_mismatch($sformatf("unexpected transaction %h", result));
				end else begin
					want = header_bytes_due.pop_front();
					if (result.header_byte !== want.header_byte)
						report_mismatch($sformatf("header_byte %h, expected %h",
							result.header_byte, want.header_byte));
					if (result.byte_position !== want.byte_position)
						report_mismatch($sformatf("byte_position %0d, expected %0d",
							result.byte_position, want.byte_position));
					if (result.last_byte !== want.last_byte)
						report_mismatch($sformatf("last_byte %b, expected %b",
							result.last_byte, want.last_byte));
					if (result.oversize !== want.oversize)
						report_mismatch($sformatf("oversize %b, expected %b",
							result.oversize, want.oversize));
				end
				result_count++;
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr == {REG_SOURCE_MAC, 3'b000})
					src_mac <= pwdata[47:0];
				else if (paddr == {REG_DESTINATION_MAC, 3'b000})
					dst_mac <= pwdata[47:0];
			end
			if (start && !busy)
				queue_header(request);
		end
		due_count = header_bytes_due.size();
	end

endmodule

/* sim/udp_ipv4_eth_header_builder_test.sv */
`timescale 1ns / 100ps
// Testbench top for the UDP/IPv4/Ethernet header builder: clock, reset, MAC writes over
// APB and request stimulus. Depends on uieb_pkg, the builder and header_stream_checker.
module udp_ipv4_eth_header_builder_test;
	import uieb_pkg::*;

	localparam int RANDOM_PER_PHASE = 43;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic          busy;
	uieb_request_t request = '0;
	uieb_result_t  result;
	logic          result_strobe;
	logic          psel = 1'b0;
	logic          penable = 1'b0;
	logic          pwrite = 1'b0;
	logic [3:0]    paddr = '0;
	logic [63:0]   pwdata = '0;
	logic [63:0]   prdata;
	logic          pready;
	int            mismatches;
	int            outstanding;

	always #4 clk = ~clk;

	udp_ipv4_eth_header_builder dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.result(result), .result_strobe(result_strobe), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	header_stream_checker stream_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.result(result), .result_strobe(result_strobe), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	task automatic write_mac(uieb_reg_idx_t idx, logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_request(uieb_request_t r, bit may_idle);
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
		if (may_idle && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic uieb_request_t make_request(logic [15:0] len, logic udp,
			logic [15:0] sport, logic [15:0] dport, logic [31:0] sip, logic [31:0] dip,
			logic [7:0] proto);
		uieb_request_t r;
		r.payload_length = len;
		r.add_udp = udp;
		r.source_port = sport;
		r.destination_port = dport;
		r.source_ip = sip;
		r.destination_ip = dip;
		r.ip_protocol = proto;
		return r;
	endfunction

	function automatic uieb_request_t random_request();
		uieb_request_t r;
		r = make_request(16'($urandom), 1'($urandom_range(0, 1)), 16'($urandom),
			16'($urandom), $urandom, $urandom, 8'($urandom));
		case ($urandom_range(0, 7))
			0: r.payload_length = 16'hFFFF - 16'($urandom_range(0, 40));
			1, 2: r.payload_length = 16'($urandom_range(0, 1500));
			default: ;
		endcase
		return r;
	endfunction

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					write_mac(REG_SOURCE_MAC, 64'hFFFF_FFFF_FFFF_FFFF);
					write_mac(REG_DESTINATION_MAC, 64'h0);
				end
				1: begin
					write_mac(REG_SOURCE_MAC, 64'h0);
					write_mac(REG_DESTINATION_MAC, 64'h0000_FFFF_FFFF_FFFF);
				end
				2: begin
					write_mac(REG_SOURCE_MAC, 64'h1234_AAAA_AAAA_AAAA);
					write_mac(REG_DESTINATION_MAC, 64'h0000_5555_5555_5555);
				end
				default: begin
					write_mac(REG_SOURCE_MAC, {$urandom, $urandom});
					write_mac(REG_DESTINATION_MAC, {$urandom, $urandom});
				end
			endcase
			if (phase == 0) begin
				send_request(make_request(16'd0, 1'b0, 16'd0, 16'd0, 32'd0, 32'd0, 8'd0), 0);
				send_request(make_request(16'd0, 1'b1, 16'd0, 16'd0, 32'd0, 32'd0, 8'd0), 0);
				send_request(make_request(16'd0, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
					32'hFFFF_FFFF, 8'hFF), 0);
				// largest lengths that still fit, and one past them
				send_request(make_request(16'd65515, 1'b0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
					32'hFFFF_FFFF, 8'hFF), 0);
				send_request(make_request(16'd65516, 1'b0, 16'd1, 16'd2, 32'h0A00_0001,
					32'h0A00_0002, 8'd17), 0);
				send_request(make_request(16'd65507, 1'b1, 16'd5000, 16'd53, 32'hC0A8_0001,
					32'hC0A8_00FE, 8'd17), 0);
				send_request(make_request(16'd65508, 1'b1, 16'd5000, 16'd53, 32'hC0A8_0001,
					32'hC0A8_00FE, 8'd17), 0);
				send_request(make_request(16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
					32'hFFFF_FFFF, 8'hFF), 0);
				send_request(make_request(16'hFFFF, 1'b0, 16'd0, 16'd0, 32'd0, 32'd0, 8'd0), 0);
				send_request(make_request(16'd512, 1'b1, 16'h8000, 16'h0001, 32'h8000_0001,
					32'h0000_8000, 8'd17), 0);
				// header sum comes to all ones, so the checksum is zero
				send_request(make_request(16'd100, 1'b0, 16'd0, 16'd0, 32'h0A00_0001,
					32'hC0A8_DFCB, 8'd17), 0);
				send_request(make_request(16'd1472, 1'b1, 16'hAAAA, 16'h5555, 32'h5555_AAAA,
					32'hAAAA_5555, 8'h55), 0);
				send_request(make_request(16'd1472, 1'b0, 16'h5555, 16'hAAAA, 32'hAAAA_5555,
					32'h5555_AAAA, 8'hAA), 0);
				send_request(make_request(16'hFFF0, 1'b0, 16'd0, 16'd0, 32'd0, 32'd0, 8'd6), 0);
				send_request(make_request(16'd1, 1'b1, 16'd1, 16'd1, 32'd1, 32'd1, 8'd1), 0);
			end
			for (int k = 0; k < RANDOM_PER_PHASE; k++)
				send_request(random_request(), phase < 4);
			wait_drained();
		end
		if (mismatches == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
